### rtl/core/iptt_pkg.sv
// ---------------------------------------------------------------------------
// iptt_pkg
// Shared types and constants for the indexed priority task table: entry
// layout, command broadcast to the cell chain, opcodes and status codes.
// ---------------------------------------------------------------------------
package iptt_pkg;

    // number of table slots, one chain cell per slot
    localparam int CAPACITY = 64;
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    localparam int ID_W    = 16;
    localparam int OWNER_W = 16;
    localparam int PRIO_W  = 16;
    localparam int KEY_W   = PRIO_W + ID_W;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_EDIT   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_EXEC   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    // task payload held by one cell
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [ID_W-1:0]    id;
        logic [OWNER_W-1:0] owner;
    } data_t;

    typedef struct packed {
        logic  valid;
        data_t data;
    } entry_t;

    // update broadcast to every cell: optional removal of the entry with
    // key rem_key, then optional sorted insertion of new_data
    typedef struct packed {
        logic             rem;
        logic             ins;
        logic [KEY_W-1:0] rem_key;
        data_t            new_data;
    } cmd_t;

    // ordering key: priority first, then task id
    function automatic logic [KEY_W-1:0] key_of(input data_t d);
        return {d.prio, d.id};
    endfunction

endpackage

### rtl/core/iptt_cell.sv
// ---------------------------------------------------------------------------
// iptt_cell
// One slot of the sorted task chain. The chain is kept in descending key
// order with all valid entries packed at the head. On commit each cell
// picks its next entry from itself, its right neighbor, the left neighbor's
// post-removal value or the inserted entry, using only local compares.
// ---------------------------------------------------------------------------
module iptt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            commit,
    input  iptt_pkg::cmd_t  cmd,
    input  logic [15:0]     look_id,
    input  iptt_pkg::entry_t right_ent,
    input  logic            right_gt,
    input  iptt_pkg::entry_t left_rl,
    input  logic            left_rl_gt,
    output iptt_pkg::entry_t ent,
    output logic            gt_new,
    output iptt_pkg::entry_t rl,
    output logic            rl_gt,
    output logic            match
);
    import iptt_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    data_t            data_reg;
    data_t            data_next;
    logic [KEY_W-1:0] own_key;
    logic             below_rem;
    entry_t           ins_ent;

    assign ent.valid = valid_reg;
    assign ent.data  = data_reg;
    assign own_key   = key_of(data_reg);

    // local compares against the broadcast keys and the lookup id
    assign match     = valid_reg && (data_reg.id == look_id);
    assign gt_new    = valid_reg && (own_key > key_of(cmd.new_data));
    assign below_rem = cmd.rem && !(valid_reg && (own_key > cmd.rem_key));

    // value of this position after the removal step
    assign rl    = below_rem ? right_ent : ent;
    assign rl_gt = below_rem ? right_gt : gt_new;

    // insertion step: keep, take the new entry, or take the left value
    always_comb
    begin
        ins_ent.valid = 1'b1;
        ins_ent.data  = cmd.new_data;
        priority if (!cmd.ins || rl_gt)
        begin
            valid_next = rl.valid;
            data_next  = rl.data;
        end
        else if (left_rl_gt)
        begin
            valid_next = ins_ent.valid;
            data_next  = ins_ent.data;
        end
        else
        begin
            valid_next = left_rl.valid;
            data_next  = left_rl.data;
        end
    end

    // slot valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (commit)
            valid_reg <= valid_next;
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        if (commit)
            data_reg <= data_next;
    end

endmodule

### rtl/core/indexed_priority_task_table_core.sv
// ---------------------------------------------------------------------------
// indexed_priority_task_table_core
// Task table kept as a sorted chain of cells with add, edit, remove by id
// and execute-top commands, one result per command.
// ---------------------------------------------------------------------------
// For every command, the edge that accepts start looks up the task id in
// all cells and latches the update; busy is high for the next cycle,
// whose closing edge shifts the cell chain (removal and sorted insertion
// in one step) and raises done. Done is high for exactly one cycle with
// top_owner, found and status valid, and start may be accepted in that
// same cycle, so the next command overlaps the result. The receiver
// cannot stall: a result not taken while done is high is lost.
// The head cell always holds the top task, so execute-top needs no search.
module indexed_priority_task_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [15:0] task_id,
    input  logic [15:0] owner,
    input  logic [15:0] prio,
    output logic        done,
    output logic [15:0] top_owner,
    output logic        found,
    output logic [1:0]  status
);
    import iptt_pkg::*;

    entry_t               ent    [CAPACITY];
    entry_t               rl     [CAPACITY];
    logic                 gt     [CAPACITY];
    logic                 rl_gt  [CAPACITY];
    logic [CAPACITY-1:0]  match_vec;

    logic                 busy_reg;
    logic                 done_reg;
    cmd_t                 cmd_reg;
    cmd_t                 cmd_next;
    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     occ_next;
    logic [15:0]          top_owner_reg;
    logic [15:0]          top_owner_next;
    logic                 found_reg;
    logic                 found_next;
    status_t              status_reg;
    status_t              status_next;

    logic                 accept;
    logic                 hit;
    data_t                hit_data;
    logic                 full;

    assign accept = start && !busy_reg;
    assign full   = (occ_reg == OCC_W'(CAPACITY));

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t right_ent;
        logic   right_gt;
        entry_t left_rl;
        logic   left_rl_gt;

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_ent = '0;
            assign right_gt  = 1'b0;
        end
        else
        begin : g_mid
            assign right_ent = ent[i+1];
            assign right_gt  = gt[i+1];
        end

        if (i == 0)
        begin : g_head
            assign left_rl    = '0;
            assign left_rl_gt = 1'b1;
        end
        else
        begin : g_body
            assign left_rl    = rl[i-1];
            assign left_rl_gt = rl_gt[i-1];
        end

        iptt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .commit     (busy_reg),
            .cmd        (cmd_reg),
            .look_id    (task_id),
            .right_ent  (right_ent),
            .right_gt   (right_gt),
            .left_rl    (left_rl),
            .left_rl_gt (left_rl_gt),
            .ent        (ent[i]),
            .gt_new     (gt[i]),
            .rl         (rl[i]),
            .rl_gt      (rl_gt[i]),
            .match      (match_vec[i])
        );
    end

    // id lookup: at most one cell matches, so an or of masked data selects it
    always_comb
    begin
        hit      = |match_vec;
        hit_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_vec[i])
                hit_data = hit_data | ent[i].data;
        end
    end

    // command decode at accept time
    always_comb
    begin
        cmd_next                = '0;
        cmd_next.rem_key        = key_of(hit_data);
        cmd_next.new_data.prio  = prio;
        cmd_next.new_data.id    = task_id;
        cmd_next.new_data.owner = owner;
        top_owner_next          = '0;
        found_next              = 1'b0;
        status_next             = ST_OK;
        unique case (opcode_t'(opcode))
            OP_ADD:
            begin
                cmd_next.rem = hit;
                cmd_next.ins = hit || !full;
                if (!hit && full)
                    status_next = ST_FULL;
            end
            OP_EDIT:
            begin
                cmd_next.rem                = hit;
                cmd_next.ins                = hit;
                cmd_next.new_data.owner     = hit_data.owner;
                if (!hit)
                    status_next = ST_UNKNOWN;
            end
            OP_REMOVE:
            begin
                cmd_next.rem = hit;
                if (!hit)
                    status_next = ST_UNKNOWN;
            end
            OP_EXEC:
            begin
                cmd_next.rem     = ent[0].valid;
                cmd_next.rem_key = key_of(ent[0].data);
                found_next       = ent[0].valid;
                if (ent[0].valid)
                    top_owner_next = ent[0].data.owner;
            end
            default:
            begin
                cmd_next = '0;
            end
        endcase
    end

    // occupancy follows the committed update
    always_comb
    begin
        occ_next = occ_reg;
        if (busy_reg)
            occ_next = occ_reg + OCC_W'(cmd_reg.ins) - OCC_W'(cmd_reg.rem);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            occ_reg  <= '0;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
            occ_reg  <= occ_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= cmd_next;
            top_owner_reg <= top_owner_next;
            found_reg     <= found_next;
            status_reg    <= status_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign top_owner = top_owner_reg;
    assign found     = found_reg;
    assign status    = status_reg;

    // every busy (commit) cycle is followed by a done cycle with busy low
    a_busy_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> done_reg && !busy_reg)
        else $error("busy cycle not followed by done");

    // an executed task is never reported with an error status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && found_reg |-> status_reg == ST_OK && occ_reg != '0 ||
        done_reg && found_reg && status_reg == ST_OK)
        else $error("found with error status");

    // occupancy stays within the table
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    // chain stays packed: head valid exactly when the table is not empty
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ent[0].valid == (occ_reg != '0))
        else $error("head cell disagrees with occupancy");

endmodule

### sim/task_table_sb_pkg.sv
// ---------------------------------------------------------------------------
// task_table_sb_pkg
// Scoreboard for the indexed priority task table: a shadow copy of the task
// table predicts the result of every accepted command, and results coming
// back from the block are checked against those predictions in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package task_table_sb_pkg;

    import iptt_pkg::*;

    // predicted result of one command
    typedef struct {
        logic [15:0] top_owner;
        logic        found;
        status_t     status;
    } outcome_t;

    class task_table_scoreboard;

        // shadow copy of the table; slot order does not matter since ids are unique
        bit          slot_used  [CAPACITY];
        logic [15:0] slot_id    [CAPACITY];
        logic [15:0] slot_owner [CAPACITY];
        logic [15:0] slot_prio  [CAPACITY];

        outcome_t    pending_outcomes [$];
        int          error_count;

        function new();
            for (int i = 0; i < CAPACITY; i++)
            begin
                slot_used[i]  = 1'b0;
                slot_id[i]    = '0;
                slot_owner[i] = '0;
                slot_prio[i]  = '0;
            end
            error_count = 0;
        endfunction

        function int outstanding();
            return pending_outcomes.size();
        endfunction

        // apply an accepted command to the shadow table and queue its result
        function void note_command(opcode_t op, logic [15:0] id, logic [15:0] own,
                                   logic [15:0] pr);
            outcome_t want;
            int       slot;
            slot           = -1;
            want.top_owner = '0;
            want.found     = 1'b0;
            want.status    = ST_OK;

            // look the id up among the valid slots
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (slot_used[i] && slot_id[i] == id)
                    slot = i;
            end

            case (op)
                OP_ADD:
                begin
                    // new id takes the first free slot, or is dropped when full
                    if (slot < 0)
                    begin
                        for (int i = CAPACITY - 1; i >= 0; i--)
                        begin
                            if (!slot_used[i])
                                slot = i;
                        end
                        if (slot < 0)
                        begin
                            want.status = ST_FULL;
                        end
                        else
                        begin
                            slot_used[slot] = 1'b1;
                            slot_id[slot]   = id;
                        end
                    end
                    if (slot >= 0)
                    begin
                        slot_owner[slot] = own;
                        slot_prio[slot]  = pr;
                    end
                end
                OP_EDIT:
                begin
                    if (slot < 0)
                        want.status = ST_UNKNOWN;
                    else
                        slot_prio[slot] = pr;
                end
                OP_REMOVE:
                begin
                    if (slot < 0)
                        want.status = ST_UNKNOWN;
                    else
                        slot_used[slot] = 1'b0;
                end
                default:
                begin
                    // execute top: highest priority, higher id on a tie
                    slot = -1;
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (slot_used[i])
                        begin
                            if (slot < 0 || slot_prio[i] > slot_prio[slot] ||
                                (slot_prio[i] == slot_prio[slot] &&
                                 slot_id[i] > slot_id[slot]))
                                slot = i;
                        end
                    end
                    if (slot >= 0)
                    begin
                        want.top_owner  = slot_owner[slot];
                        want.found      = 1'b1;
                        slot_used[slot] = 1'b0;
                    end
                end
            endcase

            // append to the tail of the prediction queue
            pending_outcomes = {pending_outcomes, want};
        endfunction

        // compare one result from the block with the oldest prediction
        function void check_result(logic [15:0] got_owner, logic got_found,
                                   logic [1:0] got_status);
            outcome_t want;
            if (pending_outcomes.size() == 0)
            begin
                $error("result with no command outstanding: top_owner %h found %b status %0d",
                       got_owner, got_found, got_status);
                error_count++;
                return;
            end
            want = pending_outcomes.pop_front();
            if (got_owner !== want.top_owner)
            begin
                $error("top_owner mismatch: expected %h, actual %h", want.top_owner, got_owner);
                error_count++;
            end
            if (got_found !== want.found)
            begin
                $error("found mismatch: expected %b, actual %b", want.found, got_found);
                error_count++;
            end
            if (got_status !== want.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got_status);
                error_count++;
            end
        endfunction

    endclass

endpackage

### sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Testbench for indexed_priority_task_table_core: a directed run through
// the corner cases, then random fill, mixed and drain segments under
// several sender idling patterns, all checked by the task table scoreboard.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import iptt_pkg::*;
    import task_table_sb_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int POOL_SIZE   = 96;
    localparam int SEG_ITEMS   = 90;
    localparam int SEG_COUNT   = 12;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [15:0] task_id;
    logic [15:0] owner;
    logic [15:0] prio;
    logic        done;
    logic [15:0] top_owner;
    logic        found;
    logic [1:0]  status;

    int          quiet_cycles;
    logic [15:0] id_pool [POOL_SIZE];

    task_table_scoreboard table_sb = new();

    indexed_priority_task_table_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .task_id   (task_id),
        .owner     (owner),
        .prio      (prio),
        .done      (done),
        .top_owner (top_owner),
        .found     (found),
        .status    (status)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // monitor: results first, then the command taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                table_sb.check_result(top_owner, found, status);
            if (start && !busy)
                table_sb.note_command(opcode_t'(opcode), task_id, owner, prio);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // present one command and hold it until accepted, then maybe idle a while
    task automatic issue_command(opcode_t op, logic [15:0] id, logic [15:0] own,
                                 logic [15:0] pr, int idle_pct);
        start   <= 1'b1;
        opcode  <= op;
        task_id <= id;
        owner   <= own;
        prio    <= pr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
            begin
                opcode  <= 2'($urandom_range(3));
                task_id <= 16'($urandom);
                owner   <= 16'($urandom);
                prio    <= 16'($urandom);
                @(posedge clk);
            end while ($urandom_range(99) < idle_pct);
        end
    endtask

    initial
    begin
        int          idle_plan [4];
        int          idle_pct;
        int          add_w;
        int          exec_w;
        int          pick;
        opcode_t     op;
        logic [15:0] id;
        logic [15:0] pr;

        idle_plan    = '{0, 62, 0, 37};
        quiet_cycles = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = '0;
        task_id      = '0;
        owner        = '0;
        prio         = '0;

        // small id pool so adds, edits and removes hit live entries
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = 16'($urandom);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, unknown ids, extremes, overwrite, ties
        issue_command(OP_EXEC,   16'h3C3C, 16'hFFFF, 16'hFFFF, 0);
        issue_command(OP_EDIT,   16'h1234, 16'h0000, 16'h0001, 0);
        issue_command(OP_REMOVE, 16'hFFFF, 16'h0000, 16'h0000, 0);
        issue_command(OP_ADD,    16'h0000, 16'h0000, 16'h0000, 0);
        issue_command(OP_ADD,    16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        issue_command(OP_ADD,    16'h0005, 16'hAAAA, 16'h8000, 0);
        issue_command(OP_ADD,    16'h0005, 16'h5555, 16'h0000, 0);
        issue_command(OP_EDIT,   16'h0000, 16'h9999, 16'hFFFF, 0);
        issue_command(OP_EXEC,   16'h0000, 16'h0000, 16'h0000, 0);
        issue_command(OP_EXEC,   16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        issue_command(OP_EDIT,   16'h0005, 16'h0000, 16'h0001, 0);
        issue_command(OP_REMOVE, 16'h0005, 16'hFFFF, 16'hFFFF, 0);
        issue_command(OP_REMOVE, 16'h0005, 16'h0000, 16'h0000, 0);
        issue_command(OP_EXEC,   16'h0005, 16'h1111, 16'h2222, 0);
        issue_command(OP_ADD,    16'h0007, 16'h0001, 16'h0003, 0);
        issue_command(OP_ADD,    16'h0008, 16'h0002, 16'h0003, 0);
        issue_command(OP_EXEC,   16'h0000, 16'h0000, 16'h0000, 0);
        issue_command(OP_EXEC,   16'h0000, 16'h0000, 16'h0000, 0);
        issue_command(OP_EXEC,   16'hA5A5, 16'h5A5A, 16'hC3C3, 0);

        // random: fill, mixed and drain segments in each idling phase
        for (int seg = 0; seg < SEG_COUNT; seg++)
        begin
            idle_pct = idle_plan[seg / 3];
            case (seg % 3)
                0:
                begin
                    add_w  = 80;
                    exec_w = 8;
                end
                1:
                begin
                    add_w  = 40;
                    exec_w = 30;
                end
                default:
                begin
                    add_w  = 15;
                    exec_w = 55;
                end
            endcase
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < add_w)
                    op = OP_ADD;
                else if (pick < add_w + exec_w)
                    op = OP_EXEC;
                else
                    op = ($urandom_range(1) != 0) ? OP_EDIT : OP_REMOVE;

                if ($urandom_range(99) < 85)
                    id = id_pool[$urandom_range(POOL_SIZE - 1)];
                else
                    id = 16'($urandom);

                // mostly narrow priorities so ties are common
                pick = $urandom_range(9);
                if (pick < 5)
                    pr = 16'($urandom_range(7));
                else if (pick < 6)
                    pr = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
                else
                    pr = 16'($urandom);

                issue_command(op, id, 16'($urandom), pr, idle_pct);
            end
        end

        // drain and let any stray result show up
        start <= 1'b0;
        @(posedge clk);
        while (table_sb.outstanding() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (table_sb.error_count == 0 && table_sb.outstanding() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/core/iptt_pkg.sv
rtl/core/iptt_cell.sv
rtl/core/indexed_priority_task_table_core.sv
sim/task_table_sb_pkg.sv
sim/tb_top.sv
